// ----- sv/ttlcd_pkg.sv -----
package ttlcd_pkg;

	localparam int unsigned PageCountDef = 8;
	localparam logic [7:0] LastColumn = 8'd131;
	localparam logic [7:0] WrapColumn = 8'd127;
	localparam logic [7:0] CmdPage = 8'hB0;
	localparam logic [7:0] CmdColHigh = 8'h10;
	localparam logic [7:0] CmdColLow = 8'h00;
	localparam logic [7:0] GlyphWidth = 8'd8;
	localparam logic [7:0] AlignMask = 8'hF8;

	localparam int unsigned GlyphDepth = 1024;
	localparam int unsigned GlyphAddrW = $clog2(GlyphDepth);
	localparam int unsigned ByteW = 8;

	// 8 glyph columns of (3 commands + 1 data) plus a closing cursor triple
	localparam int unsigned RunBytes = 35;
	localparam int unsigned IdxW = $clog2(RunBytes);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(RunBytes - 1);

	localparam logic [1:0] PosPage = 2'd0;
	localparam logic [1:0] PosColHigh = 2'd1;
	localparam logic [1:0] PosColLow = 2'd2;
	localparam logic [1:0] PosData = 2'd3;

	localparam logic [6:0] GlyphFirst = 7'd32;
	localparam int unsigned GlyphCount = 96;

	// bytes 1..5 of each glyph from code 32 upward, byte 1 in the top bits
	localparam logic [39:0] FontCore [GlyphCount] = '{
		40'h0000000000, 40'h00004F0000, 40'h0000000000, 40'h0000000000,
		40'h0000000000, 40'h2313086462, 40'h0000000000, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h08083E0808,
		40'h0000000000, 40'h0808080808, 40'h6060000000, 40'h0000000000,
		40'h3E4141413E, 40'h44427F4040, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h2C4A494930, 40'h0301710907,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0000000000,
		40'h0000000000, 40'h1414141414, 40'h0000000000, 40'h0201510906,
		40'h0000000000, 40'h3C1211123C, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3F41494972,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408027F, 40'h3F4141413F,
		40'h7F09090906, 40'h3F4151215E, 40'h7F09192946, 40'h2649494932,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000,
		40'h0000000000, 40'h1054545478, 40'h7F48444438, 40'h3844444420,
		40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040443400, 40'h7F10284400,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4038403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0705070000
	};

	// one byte of the font image, by flat ROM address {code, column}
	function automatic logic [ByteW-1:0] glyph_byte(input logic [GlyphAddrW-1:0] addr);
		logic [6:0] code;
		logic [2:0] col;
		logic [39:0] row;
		logic [ByteW-1:0] res;
		code = addr[GlyphAddrW-1:3];
		col = addr[2:0];
		res = '0;
		if (code >= GlyphFirst && col >= 3'd1 && col <= 3'd5) begin
			row = FontCore[7'(code - GlyphFirst)];
			res = row[(5 - int'(col)) * 8 +: 8];
		end
		return res;
	endfunction

	typedef struct packed {
		logic valid;
		logic [ByteW-1:0] value;
		logic is_data;
		logic last;
		logic blank;
		logic [GlyphAddrW-1:0] rom_addr;
	} issue_t;

endpackage

// ----- sv/ttlcd_ram.sv -----
module ttlcd_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/ttlcd_seq.sv -----
module ttlcd_seq #(
	parameter int unsigned PAGE_COUNT = ttlcd_pkg::PageCountDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  enable,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_code,
	input  logic                  advance,
	output ttlcd_pkg::issue_t     issue
);

	localparam int unsigned PageW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam logic [PageW-1:0] PageMax = PageW'(PAGE_COUNT - 1);

	logic                        pend_valid_q;
	logic [7:0]                  pend_code_q;
	logic                        active_q;
	logic [ttlcd_pkg::IdxW-1:0]  idx_q;
	logic [7:0]                  code_q;
	logic [7:0]                  col_q;
	logic [PageW-1:0]            page_q;
	logic [7:0]                  cur_col_q;
	logic [PageW-1:0]            cur_page_q;

	logic             take;
	logic [7:0]       start_col;
	logic [PageW-1:0] start_page;
	logic [3:0]       grp;
	logic [1:0]       pos;
	logic [7:0]       col_cur;
	logic [7:0]       mirrored;

	assign in_ready = enable && !pend_valid_q;
	assign take = pend_valid_q && (!active_q || (advance && idx_q == ttlcd_pkg::LastIdx));

	// column wrap moves to the next page straight away
	always_comb begin
		if (cur_col_q > ttlcd_pkg::WrapColumn) begin
			start_col = '0;
			start_page = (cur_page_q == PageMax) ? '0 : cur_page_q + PageW'(1);
		end else begin
			start_col = cur_col_q & ttlcd_pkg::AlignMask;
			start_page = cur_page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			active_q <= 1'b0;
			idx_q <= '0;
			cur_col_q <= '0;
			cur_page_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				pend_valid_q <= 1'b1;
			end else if (take) begin
				pend_valid_q <= 1'b0;
			end
			if (take) begin
				active_q <= 1'b1;
				idx_q <= '0;
				cur_col_q <= start_col + ttlcd_pkg::GlyphWidth;
				cur_page_q <= start_page;
			end else if (advance && active_q) begin
				if (idx_q == ttlcd_pkg::LastIdx) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + ttlcd_pkg::IdxW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pend_code_q <= char_code;
		end
		if (take) begin
			code_q <= pend_code_q;
			col_q <= start_col;
			page_q <= start_page;
		end
	end

	assign grp = idx_q[ttlcd_pkg::IdxW-1:2];
	assign pos = idx_q[1:0];
	assign col_cur = col_q + {4'b0, grp};
	assign mirrored = ttlcd_pkg::LastColumn - col_cur;

	always_comb begin
		issue.valid = active_q;
		issue.is_data = (pos == ttlcd_pkg::PosData);
		issue.last = (idx_q == ttlcd_pkg::LastIdx);
		issue.blank = code_q[7];
		issue.rom_addr = {code_q[6:0], grp[2:0]};
		case (pos)
			ttlcd_pkg::PosPage: issue.value = ttlcd_pkg::CmdPage + 8'(page_q);
			ttlcd_pkg::PosColHigh: issue.value = ttlcd_pkg::CmdColHigh + {4'b0, mirrored[7:4]};
			ttlcd_pkg::PosColLow: issue.value = ttlcd_pkg::CmdColLow + {4'b0, mirrored[3:0]};
			default: issue.value = '0;
		endcase
	end

endmodule

// ----- sv/text_to_lcd_command_stream.sv -----
// A request passes the input buffer, the active flag and the output register in turn.
// One byte per cycle while out_ready holds high, 35 per character, from the sequencer;
// a one-entry input buffer lets the next character start straight after the last byte.
// Reset: cursor goes to column 0, page 0; the font memory is then loaded, all 1024
// entries, one entry a cycle, with in_ready held low until the load is done.
module text_to_lcd_command_stream #(
	parameter int unsigned PAGE_COUNT = ttlcd_pkg::PageCountDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last
);

	logic                               fill_done_q;
	logic [ttlcd_pkg::GlyphAddrW-1:0]   fill_addr_q;
	logic                               advance;
	ttlcd_pkg::issue_t                  issue;
	logic [ttlcd_pkg::ByteW-1:0]        rom_rdata;

	logic                               valid_s1;
	logic [ttlcd_pkg::ByteW-1:0]        value_s1;
	logic                               is_data_s1;
	logic                               last_s1;
	logic                               blank_s1;

	// font load sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_done_q <= 1'b0;
			fill_addr_q <= '0;
		end else if (!fill_done_q) begin
			fill_addr_q <= fill_addr_q + ttlcd_pkg::GlyphAddrW'(1);
			if (fill_addr_q == ttlcd_pkg::GlyphAddrW'(ttlcd_pkg::GlyphDepth - 1)) begin
				fill_done_q <= 1'b1;
			end
		end
	end

	assign advance = !valid_s1 || out_ready;

	ttlcd_seq #(
		.PAGE_COUNT(PAGE_COUNT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (fill_done_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_code(char_code),
		.advance  (advance),
		.issue    (issue)
	);

	// read data only moves on advance, so it holds while the output is stalled
	ttlcd_ram #(
		.Width(ttlcd_pkg::ByteW),
		.Depth(ttlcd_pkg::GlyphDepth)
	) u_glyph_ram (
		.clk  (clk),
		.we   (!fill_done_q),
		.waddr(fill_addr_q),
		.wdata(ttlcd_pkg::glyph_byte(fill_addr_q)),
		.re   (advance && issue.valid),
		.raddr(issue.rom_addr),
		.rdata(rom_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_s1 <= issue.value;
			is_data_s1 <= issue.is_data;
			last_s1 <= issue.last;
			blank_s1 <= issue.blank;
		end
	end

	assign out_valid = valid_s1;
	assign is_data = is_data_s1;
	assign last = last_s1;
	assign out_byte = is_data_s1 ? (blank_s1 ? '0 : rom_rdata) : value_s1;

endmodule

// ----- test/text_to_lcd_command_stream_tb.sv -----
module text_to_lcd_command_stream_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NumPages = 8;
	localparam logic [7:0] MirrorBase = 8'd131;
	localparam logic [7:0] WrapLimit = 8'd127;
	localparam logic [7:0] ColMask = 8'hF8;
	localparam logic [7:0] PageCmd = 8'hB0;
	localparam logic [7:0] ColHighCmd = 8'h10;
	localparam logic [7:0] ColLowCmd = 8'h00;
	localparam logic [7:0] FirstGlyph = 8'd32;
	localparam int RandomChars = 210;
	localparam int HoldCycles = 400;

	// glyph bytes 1..5 from code 32 upward, byte 1 in the top bits
	localparam logic [39:0] GlyphBits [96] = '{
		40'h0000000000, 40'h00004F0000, 40'h0000000000, 40'h0000000000,
		40'h0000000000, 40'h2313086462, 40'h0000000000, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h08083E0808,
		40'h0000000000, 40'h0808080808, 40'h6060000000, 40'h0000000000,
		40'h3E4141413E, 40'h44427F4040, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h2C4A494930, 40'h0301710907,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0000000000,
		40'h0000000000, 40'h1414141414, 40'h0000000000, 40'h0201510906,
		40'h0000000000, 40'h3C1211123C, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3F41494972,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408027F, 40'h3F4141413F,
		40'h7F09090906, 40'h3F4151215E, 40'h7F09192946, 40'h2649494932,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000,
		40'h0000000000, 40'h1054545478, 40'h7F48444438, 40'h3844444420,
		40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040443400, 40'h7F10284400,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4038403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0705070000
	};

	typedef struct packed {
		logic [7:0] value;
		logic is_data;
		logic last;
	} lcd_byte_t;

	typedef enum int {
		RdyAlways,
		RdyCoin,
		RdySparse,
		RdyPeriodic
	} ready_mode_t;

	class lcd_stream_scoreboard;
		lcd_byte_t pending_bytes[$];
		logic [7:0] text_col;
		int text_page;
		int errors;

		function new();
			text_col = 8'd0;
			text_page = 0;
			errors = 0;
		endfunction

		function logic [7:0] glyph_column(logic [7:0] code, int idx);
			logic [39:0] row;
			logic [7:0] res;
			res = 8'h00;
			if (code >= FirstGlyph && code <= WrapLimit && idx >= 1 && idx <= 5) begin
				row = GlyphBits[code - FirstGlyph];
				res = row[(5 - idx) * 8 +: 8];
			end
			return res;
		endfunction

		function void push_cursor(logic [7:0] c, int p, logic fin);
			logic [7:0] mirrored;
			mirrored = MirrorBase - c;
			pending_bytes.push_back('{value: PageCmd + 8'(p), is_data: 1'b0, last: 1'b0});
			pending_bytes.push_back('{value: ColHighCmd + {4'h0, mirrored[7:4]},
				is_data: 1'b0, last: 1'b0});
			pending_bytes.push_back('{value: ColLowCmd + {4'h0, mirrored[3:0]},
				is_data: 1'b0, last: fin});
		endfunction

		// one accepted request: 35 bytes for the glyph at the current cursor
		function void note_char(logic [7:0] code);
			logic [7:0] c;
			int p;
			c = text_col;
			p = text_page;
			if (c > WrapLimit) begin
				c = 8'd0;
				p = (p + 1) % NumPages;
			end
			c = c & ColMask;
			for (int i = 0; i < 8; i++) begin
				push_cursor(c + 8'(i), p, 1'b0);
				pending_bytes.push_back('{value: glyph_column(code, i), is_data: 1'b1,
					last: 1'b0});
			end
			push_cursor(c + 8'd8, p, 1'b1);
			text_col = c + 8'd8;
			text_page = p;
		endfunction

		function void check_byte(logic [7:0] v, logic d, logic l);
			lcd_byte_t exp_b;
			if (pending_bytes.size() == 0) begin
				$error("unexpected byte: out_byte=%02h is_data=%0b last=%0b", v, d, l);
				errors++;
				return;
			end
			exp_b = pending_bytes.pop_front();
			if (v !== exp_b.value) begin
				$error("out_byte: expected %02h, got %02h", exp_b.value, v);
				errors++;
			end
			if (d !== exp_b.is_data) begin
				$error("is_data: expected %0b, got %0b", exp_b.is_data, d);
				errors++;
			end
			if (l !== exp_b.last) begin
				$error("last: expected %0b, got %0b", exp_b.last, l);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] char_code;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_byte;
	logic is_data;
	logic last;
	bit hold_req = 1'b0;

	lcd_stream_scoreboard sb = new();

	text_to_lcd_command_stream u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.is_data(is_data),
		.last(last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_byte(out_byte, is_data, last);
	end

	// receiver: stall pattern changes every so often; long hold-off on request
	initial begin
		ready_mode_t mode;
		int phase_left;
		int k;
		out_ready <= 1'b0;
		mode = RdyAlways;
		phase_left = 0;
		k = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode = ready_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(20, 120);
					k = 0;
				end
				phase_left--;
				k++;
				case (mode)
					RdyAlways: out_ready <= 1'b1;
					RdyCoin: out_ready <= 1'($urandom_range(0, 1));
					RdySparse: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (k % 5 != 0);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_char(input logic [7:0] code);
		in_valid <= 1'b1;
		char_code <= code;
		do @(posedge clk); while (!in_ready);
		sb.note_char(code);
	endtask

	task automatic send_codes(input logic [7:0] codes[$]);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 12);
		foreach (codes[n]) begin
			send_char(codes[n]);
			burst_left--;
			if (burst_left == 0 && n != codes.size() - 1) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				// now and then a long unbroken run
				burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
			end
		end
	endtask

	task automatic drain_output();
		in_valid <= 1'b0;
		while (sb.pending_bytes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_code();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return 8'($urandom_range(32, 127));
		else if (sel < 16)
			return 8'($urandom_range(0, 31));
		else if (sel < 18)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [7:0] directed[$];
		logic [7:0] batch[$];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_code <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, blank codes above 127, last glyph, control codes;
		// enough characters to cross the column wrap into the next page
		directed = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd126, 8'd32, 8'd33, 8'd31,
			8'd65, 8'd90, 8'd97, 8'd122, 8'd48, 8'd57, 8'd37, 8'h55, 8'hAA,
			8'd1, 8'h80, 8'hFE, 8'd64, 8'd46};
		send_codes(directed);
		drain_output();

		for (int n = 0; n < 70; n++)
			batch.push_back(pick_code());
		send_codes(batch);

		// receiver goes quiet while requests keep coming
		hold_req = 1'b1;
		batch.delete();
		for (int n = 70; n < RandomChars; n++)
			batch.push_back(pick_code());
		send_codes(batch);
		drain_output();
		repeat (50) @(posedge clk);

		if (sb.pending_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", sb.pending_bytes.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
